// ----- design/median_filter_3x3_bgra_top_macros.svh -----
// assertion macros for the median filter top level
`ifndef MEDIAN_FILTER_3X3_BGRA_TOP_MACROS_SVH
`define MEDIAN_FILTER_3X3_BGRA_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define MF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MF_ASSERT_NEVER(lbl, cond, msg)
`define MF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/mf_pkg.sv -----
// shared types, constants and the median network for the median filter
package mf_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int ROW_W      = FH_W + 1;
  localparam int PIX_W      = 32;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MED_STEPS  = 19;
  localparam int MED_CENTRE = 4;

  localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [3:0] PAIR_LO [MED_STEPS] =
    '{4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
      4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4};
  localparam logic [3:0] PAIR_HI [MED_STEPS] =
    '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
      4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2};

  typedef logic [8:0][23:0] win_px_t;

  typedef struct packed {
    win_px_t    px;
    logic [7:0] alpha;
    logic       last;
  } med_item_t;

  typedef struct packed {
    logic      valid;
    med_item_t item;
  } mf_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              nonempty;
  } mf_qstat_t;

  // compare-exchange steps first..last of the nine-input median network
  function automatic win_px_t med_steps(input win_px_t v, input int first, input int last);
    win_px_t    r;
    logic [7:0] a;
    logic [7:0] b;
    logic [3:0] lo;
    logic [3:0] hi;
    r = v;
    for (int s = 0; s < MED_STEPS; s++) begin
      if (s >= first && s <= last) begin
        lo = PAIR_LO[s];
        hi = PAIR_HI[s];
        for (int ch = 0; ch < 3; ch++) begin
          a = r[lo][8*ch +: 8];
          b = r[hi][8*ch +: 8];
          if (a > b) begin
            r[lo][8*ch +: 8] = b;
            r[hi][8*ch +: 8] = a;
          end
        end
      end
    end
    return r;
  endfunction
endpackage

// ----- design/mf_if.sv -----
// channel interfaces: pixel input, result output and register writes
interface mf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [mf_pkg::PIX_W-1:0]   in_pixel;
  modport source (output valid, output opcode, output in_pixel, input ready);
  modport sink   (input valid, input opcode, input in_pixel, output ready);
endinterface

interface mf_out_if;
  logic                       valid;
  logic                       ready;
  logic [mf_pkg::PIX_W-1:0]   out_pixel;
  logic                       frame_last;
  modport source (output valid, output out_pixel, output frame_last, input ready);
  modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

interface mf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mf_pkg::CFG_IDX_W-1:0]    index;
  logic [mf_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/mf_front.sv -----
// front end: registers, position counters, line stores and the 3x3 window
module mf_front (
  input  logic              clk,
  input  logic              rst_n,
  mf_in_if.sink             in_bus,
  mf_cfg_if.sink            cfg_bus,
  input  mf_pkg::mf_qstat_t qstat,
  output mf_pkg::mf_push_t  push
);
  import mf_pkg::*;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [FW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             acc, drain, final_c, ignore, act, col_last, outp_c;

  logic             s1_v_r, s1_final_r, s1_col0_r, s1_topmid_r, s1_drain_r, s1_outp_r;
  logic [COL_W-1:0] s1_ic_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_fwd_r, s1_fwd_nxt;
  logic [PIX_W-1:0] fwd_up_r, fwd_mid_r;
  logic [PIX_W-1:0] up_q_r, mid_q_r;
  logic [PIX_W-1:0] up_rd, mid_rd, top_c, bot_c;
  logic             s1_wr;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [8:0][PIX_W-1:0] win_r, win_nxt;
  logic [QCNT_W-1:0]     occ;

  function automatic med_item_t pick(input logic [8:0][PIX_W-1:0] w, input int c0,
                                     input int c1, input int c2, input logic last);
    med_item_t it;
    int        cols [3];
    cols[0] = c0;
    cols[1] = c1;
    cols[2] = c2;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        it.px[r*3+k] = w[cols[k]*3+r][23:0];
      end
    end
    it.alpha = w[c1*3+1][31:24];
    it.last  = last;
    return it;
  endfunction

  // register writes
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= RESET_WIDTH;
      fh_r <= RESET_HEIGHT;
    end else if (cfg_bus.valid) begin
      if (cfg_bus.index == REG_FRAME_WIDTH) fw_r <= cfg_bus.data[FW_W-1:0];
      if (cfg_bus.index == REG_FRAME_HEIGHT) fh_r <= cfg_bus.data[FH_W-1:0];
    end
  end

  always_comb begin
    if (fw_r == '0) w_eff = FW_W'(1);
    else if (fw_r > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
    else w_eff = fw_r;
    h_eff = (fh_r == '0) ? ROW_W'(1) : {1'b0, fh_r};
  end

  // items that may still land in the queue decide whether a beat is taken
  assign occ          = qstat.count + QCNT_W'(s1_v_r && s1_outp_r);
  assign in_bus.ready = (occ < QCNT_W'(QDEPTH));
  assign acc          = in_bus.valid && in_bus.ready;
  assign drain        = (row_r >= h_eff);
  assign final_c      = (row_r > h_eff);
  assign ignore       = !drain && (in_bus.opcode == OP_FLUSH);
  assign act          = acc && !ignore;
  assign col_last     = ({1'b0, col_r} + FW_W'(1)) >= w_eff;
  assign outp_c       = final_c || ((col_r == '0) ? (row_r >= ROW_W'(2)) : (row_r != '0));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (act) begin
      if (final_c) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  assign s1_wr      = s1_v_r && !s1_final_r && !s1_drain_r;
  assign s1_fwd_nxt = act && !final_c && s1_wr && (s1_ic_r == col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      s1_fwd_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_v_r   <= act;
      s1_fwd_r <= s1_fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_final_r  <= final_c;
      s1_col0_r   <= (col_r == '0);
      s1_topmid_r <= (row_r == ROW_W'(1));
      s1_drain_r  <= drain;
      s1_outp_r   <= outp_c;
      s1_ic_r     <= col_r;
      s1_pix_r    <= in_bus.in_pixel;
    end
    fwd_up_r  <= mid_rd;
    fwd_mid_r <= s1_pix_r;
  end

  // line stores, read a beat ahead of the window update
  always_ff @(posedge clk) begin
    if (act && !final_c) begin
      up_q_r  <= upper_mem[col_r];
      mid_q_r <= middle_mem[col_r];
    end
    if (s1_wr) begin
      upper_mem[s1_ic_r]  <= mid_rd;
      middle_mem[s1_ic_r] <= s1_pix_r;
    end
  end

  // same column written by the previous beat when the row is one pixel wide
  assign up_rd  = s1_fwd_r ? fwd_up_r  : up_q_r;
  assign mid_rd = s1_fwd_r ? fwd_mid_r : mid_q_r;
  assign top_c  = s1_topmid_r ? mid_rd : up_rd;
  assign bot_c  = s1_drain_r ? mid_rd : s1_pix_r;

  always_comb begin
    win_nxt = win_r;
    if (s1_v_r && !s1_final_r) begin
      if (s1_col0_r) begin
        for (int c = 0; c < 3; c++) begin
          win_nxt[c*3+0] = top_c;
          win_nxt[c*3+1] = mid_rd;
          win_nxt[c*3+2] = bot_c;
        end
      end else begin
        for (int i = 0; i < 6; i++) win_nxt[i] = win_r[i+3];
        win_nxt[6] = top_c;
        win_nxt[7] = mid_rd;
        win_nxt[8] = bot_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) win_r <= '0;
    else win_r <= win_nxt;
  end

  always_comb begin
    push.valid = s1_v_r && s1_outp_r;
    if (s1_final_r || s1_col0_r) push.item = pick(win_r, 1, 2, 2, s1_final_r);
    else push.item = pick(win_nxt, 0, 1, 2, 1'b0);
  end
endmodule

// ----- design/mf_queue.sv -----
// short queue of windows between the front end and the median pipeline
module mf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  mf_pkg::mf_push_t   push,
  input  logic               pop,
  output mf_pkg::med_item_t  head,
  output mf_pkg::mf_qstat_t  qstat
);
  import mf_pkg::*;

  med_item_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push.valid && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.valid) wp_r <= wp_r + QPTR_W'(1);
      if (pop) rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) slot_r[wp_r] <= push.item;
  end

  assign head           = slot_r[rp_r];
  assign qstat.count    = cnt_r;
  assign qstat.nonempty = (cnt_r != '0);
endmodule

// ----- design/mf_back.sv -----
// back end: pipelined median network and the output register
module mf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mf_pkg::med_item_t head,
  input  logic              nonempty,
  output logic              pop,
  mf_out_if.source          out_bus
);
  import mf_pkg::*;

  logic      adv;
  logic      a_v_r, b_v_r, o_v_r;
  med_item_t a_r, b_r;
  win_px_t   c_px;
  logic [PIX_W-1:0] o_pix_r;
  logic      o_last_r;

  assign adv = !o_v_r || out_bus.ready;
  assign pop = nonempty && adv;
  assign c_px = med_steps(b_r.px, 16, 18);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= pop;
      b_v_r <= a_v_r;
      o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r.px    <= med_steps(head.px, 0, 8);
      a_r.alpha <= head.alpha;
      a_r.last  <= head.last;
      b_r.px    <= med_steps(a_r.px, 9, 15);
      b_r.alpha <= a_r.alpha;
      b_r.last  <= a_r.last;
      o_pix_r   <= {b_r.alpha, c_px[MED_CENTRE]};
      o_last_r  <= b_r.last;
    end
  end

  assign out_bus.valid      = o_v_r;
  assign out_bus.out_pixel  = o_pix_r;
  assign out_bus.frame_last = o_last_r;
endmodule

// ----- design/median_filter_3x3_bgra_top.sv -----
// top level of the 3x3 median filter for bgra pixel streams
//
//  channel  | ports      | beat carries
//  ---------+------------+------------------------------------
//  input    | in_bus.*   | opcode, in_pixel
//  result   | out_bus.*  | out_pixel, frame_last
//  config   | cfg_bus.*  | index, data (always ready)
//
// one beat per clock in and out when neither side stalls; the accepting edge
// reads the line stores, and the result passes the window and queue write,
// two median stages and the output register before it is offered. no clearing
// pass after reset. the line stores give one read and one write a cycle, which
// sets the rate. input stalls only while the four-entry queue is spoken for.
`include "median_filter_3x3_bgra_top_macros.svh"
module median_filter_3x3_bgra_top (
  input  logic      clk,
  input  logic      rst_n,
  mf_in_if.sink     in_bus,
  mf_out_if.source  out_bus,
  mf_cfg_if.sink    cfg_bus
);
  import mf_pkg::*;

  mf_push_t  push;
  mf_qstat_t qstat;
  med_item_t head;
  logic      pop;

  mf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .qstat   (qstat),
    .push    (push)
  );

  mf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  mf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .nonempty (qstat.nonempty),
    .pop      (pop),
    .out_bus  (out_bus)
  );

  `MF_ASSERT_NEVER(a_q_bound, qstat.count > QCNT_W'(QDEPTH), "queue count beyond depth")
  `MF_ASSERT_NEVER(a_q_push_full, push.valid && qstat.count == QCNT_W'(QDEPTH), "push into full queue")
  `MF_ASSERT_NEXT(a_q_pop_empty, !qstat.nonempty, !pop || qstat.count != '0, "pop from empty queue")
endmodule

// ----- tb/median_filter_3x3_bgra_top_test.sv -----
// self-checking testbench for the 3x3 bgra median filter top level
`timescale 1ns / 100ps

module median_filter_3x3_bgra_top_test;
  import mf_pkg::*;

  localparam int TIMEOUT_CYCLES = 600000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 300;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        op;
    logic [31:0] pix;
    logic        typed;
    logic [31:0] want_pix;
    logic        want_last;
  } stim_row_t;

  typedef struct {
    logic [31:0] pix;
    logic        last;
  } median_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mf_in_if  in_bus ();
  mf_out_if out_bus ();
  mf_cfg_if cfg_bus ();

  median_filter_3x3_bgra_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the filter state
  logic [31:0] upper_row [MAX_WIDTH];
  logic [31:0] middle_row [MAX_WIDTH];
  logic [31:0] win [9];
  int unsigned in_col, in_row, out_col, out_row;
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;

  median_px_t pending_px[$];
  int unsigned cycles = 0;
  int errors = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;

  localparam int NET_LO [19] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int NET_HI [19] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  function automatic logic [7:0] median_of_nine(input logic [7:0] v [9]);
    logic [7:0] t;
    for (int s = 0; s < 19; s++) begin
      if (v[NET_LO[s]] > v[NET_HI[s]]) begin
        t = v[NET_LO[s]];
        v[NET_LO[s]] = v[NET_HI[s]];
        v[NET_HI[s]] = t;
      end
    end
    return v[4];
  endfunction

  function automatic logic [31:0] window_median(input int c0, input int c1, input int c2);
    logic [31:0] res;
    logic [7:0] v [9];
    int cols [3];
    res = win[c1*3+1] & 32'hFF000000;
    cols = '{c0, c1, c2};
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          v[r*3+k] = win[cols[k]*3+r][8*ch +: 8];
      res[8*ch +: 8] = median_of_nine(v);
    end
    return res;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic void emit_px(input logic [31:0] p, input logic last, input int unsigned w);
    median_px_t e;
    e.pix = p;
    e.last = last;
    pending_px.push_back(e);
    if (last) begin
      out_col = 0;
      out_row = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row = (out_row + 1) & 16'hFFFF;
    end else begin
      out_col++;
    end
  endfunction

  // advances the shadow by one accepted beat, queueing any median pixel
  function automatic void filter_beat(input logic op, input logic [31:0] pix);
    int unsigned w, h, ic, ir;
    logic [31:0] up, mid, top, bottom;
    bit drain;
    w = eff_width();
    h = (height_reg == 0) ? 1 : height_reg;
    drain = in_row >= h;
    if (!drain && op == OP_FLUSH) return;
    if (in_row >= h + 1) begin
      emit_px(window_median(1, 2, 2), 1'b1, w);
      in_col = 0;
      in_row = 0;
      return;
    end
    ic = in_col % MAX_WIDTH;
    ir = in_row;
    up = upper_row[ic];
    mid = middle_row[ic];
    bottom = drain ? mid : pix;
    top = (ir == 1) ? mid : up;
    if (!drain) begin
      upper_row[ic] = mid;
      middle_row[ic] = pix;
    end
    if (ic == 0) begin
      if (ir >= 2) emit_px(window_median(1, 2, 2), 1'b0, w);
      for (int c = 0; c < 3; c++) begin
        win[c*3] = top;
        win[c*3+1] = mid;
        win[c*3+2] = bottom;
      end
    end else begin
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top;
      win[7] = mid;
      win[8] = bottom;
      if (ir >= 1) emit_px(window_median(0, 1, 2), 1'b0, w);
    end
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
  endfunction

  task automatic send_beat(input logic op, input logic [31:0] pix, input bit use_shadow);
    if (tx_idle && $urandom_range(0, 9) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.opcode <= op;
    in_bus.in_pixel <= pix;
    do @(posedge clk); while (!in_bus.ready);
    if (use_shadow) filter_beat(op, pix);
  endtask

  task automatic stop_sending();
    in_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves valid raised; the caller drops it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) height_reg = val;
  endtask

  task automatic set_size(input int w, input int h);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_pixel();
    logic [31:0] p;
    logic [7:0] base;
    if ($urandom_range(0, 1)) return $urandom;
    base = 8'($urandom);
    p[31:24] = 8'($urandom);
    for (int ch = 0; ch < 3; ch++) p[8*ch +: 8] = base + 8'($urandom_range(0, 6));
    return p;
  endfunction

  // one frame: mostly clean, with stray flushes and pixels in the drain
  task automatic run_frame(input int w, input int h, input bit squeeze, input bit noisy);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_beat(OP_FLUSH, $urandom, 1'b1);
      if (squeeze && i == (w * h) / 2) hold_req = 1'b1;
      send_beat(OP_PIXEL, random_pixel(), 1'b1);
    end
    for (int i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_beat(OP_PIXEL, $urandom, 1'b1);
      else send_beat(OP_FLUSH, $urandom, 1'b1);
    end
  endtask

  stim_row_t stim_rows [$] = '{
    '{ROW_REG,  OP_PIXEL, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{ROW_BEAT, OP_PIXEL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_BEAT, OP_PIXEL, 32'h80FF_00AA, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b1, 32'h80FF_00AA, 1'b1},
    '{ROW_REG,  OP_PIXEL, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'h00FF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'hFF00_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'h0102_0304, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'h7F80_7F80, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'hAA55_AA55, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'h55AA_55AA, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_PIXEL, 32'h0F0F_F0F0, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_BEAT, OP_FLUSH, 32'h0000_0000, 1'b0, 32'h0, 1'b0}
  };

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_bus.ready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    median_px_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: pixel %h last %b", out_bus.out_pixel, out_bus.frame_last);
      end else begin
        e = pending_px.pop_front();
        if (e.pix !== out_bus.out_pixel || e.last !== out_bus.frame_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected pixel %h last %b, got pixel %h last %b",
                     e.pix, e.last, out_bus.out_pixel, out_bus.frame_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("median_filter_3x3_bgra_top_test: FAIL");
      $finish;
    end
  end

  initial begin
    median_px_t e;
    int w, h;
    int sizes_w [8] = '{1, 2, 5, 80, 1, 7, 16, 3};
    int sizes_h [8] = '{1, 3, 4, 1, 7, 2, 3, 65535};
    int frame_beats;
    in_bus.valid <= 1'b0;
    in_bus.opcode <= OP_PIXEL;
    in_bus.in_pixel <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_FRAME_WIDTH;
    cfg_bus.data <= '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; register rows set a square size of the given side
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        set_size(stim_rows[i].pix, stim_rows[i].pix);
      end else if (stim_rows[i].typed) begin
        send_beat(stim_rows[i].op, stim_rows[i].pix, 1'b0);
        if (stim_rows[i].want_last) begin
          e.pix = stim_rows[i].want_pix;
          e.last = 1'b1;
          pending_px.push_back(e);
        end
        for (int k = 0; k < 9; k++) win[k] = stim_rows[i].want_pix;
        if (stim_rows[i].want_last) begin
          in_col = 0;
          in_row = 0;
        end
      end else begin
        send_beat(stim_rows[i].op, stim_rows[i].pix, 1'b1);
      end
    end

    for (int p = 0; p < 8; p++) begin
      w = sizes_w[p];
      h = sizes_h[p];
      set_size(w, h);
      if (p >= 6) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if (p == 7) begin
        // tall frame, only its first rows are sent
        for (int i = 0; i < w * 40; i++) send_beat(OP_PIXEL, random_pixel(), 1'b1);
      end else begin
        frame_beats = 0;
        do begin
          run_frame(w, h, p == 2 && frame_beats == 0, 1'b1);
          frame_beats += w * h + w + 1;
          if ($urandom_range(0, 3) == 0) wait_drained();
        end while (frame_beats < 160);
      end
    end

    stop_sending();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("median_filter_3x3_bgra_top_test: PASS");
    else
      $display("median_filter_3x3_bgra_top_test: FAIL");
    $finish;
  end
endmodule

// ----- median_filter_3x3_bgra_top.f -----
+incdir+design
design/mf_pkg.sv
design/mf_if.sv
design/mf_front.sv
design/mf_queue.sv
design/mf_back.sv
design/median_filter_3x3_bgra_top.sv
tb/median_filter_3x3_bgra_top_test.sv
